### hdl/vnns_pkg.sv
// shared constants for the nearest-neighbour voxel resampler
// field widths, register indexes, status codes and parameter defaults
// no dependencies
package vnns_pkg;

    localparam int COORD_W   = 32;
    localparam int EXT_W     = COORD_W + 2;
    localparam int DIM_W     = 9;
    localparam int NUM_W     = 2 * DIM_W;
    localparam int STEP_W    = $clog2(NUM_W + 1);
    localparam int VALUE_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int TGT_W     = 3 * DIM_W;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_DIM_DEF    = 256;
    localparam int MAX_SPAN_DEF   = 4;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGETS   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DIMS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BOUNDS   = 3'd5;

    localparam logic [DIM_W-1:0] SIZE_RESET    = 9'd1;
    localparam logic [TGT_W-1:0] TARGETS_RESET = 27'd262657;

endpackage

### hdl/voxel_nearest_neighbor_scaler_unit.sv
// nearest-neighbour voxel resampler, top level
// one shared restoring divider under a small sequencer, output register
// depends on vnns_pkg
//
// usage
// - input channel: in_valid / in_stall carries one source voxel per beat;
//   in_stall is high whenever the block is busy with an item
// - output channel: out_valid / out_stall carries destination beats in
//   z, y, x order (x fastest), or a single status beat; out_stall holds
//   the beat in the output register and pauses the sequencer in its emit and report states
// - configuration: cfg_write / cfg_index / cfg_data, written while idle
// - per item: a check state, six divisions of (local or local+1) * target
//   by the source extent, each a load step then one quotient bit per step,
//   then a span and an overflow state; destinations follow one per cycle
//   (up to 64) while out_stall is low, and the next source beat is taken
//   only once the sequencer is back in idle after the item's last beat
// - a range or dimension error at the check goes straight to the report state for its beat
// - the divider's one quotient bit per cycle sets the item rate
// - reset clears the running bounds, the run flags and the sequencer and
//   returns the registers to their reset values; no clearing pass
module voxel_nearest_neighbor_scaler_unit #(
    parameter int MAX_DIM    = vnns_pkg::MAX_DIM_DEF,
    parameter int MAX_SPAN   = vnns_pkg::MAX_SPAN_DEF,
    parameter int COORD_BITS = vnns_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [vnns_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vnns_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vnns_pkg::COORD_W-1:0]   src_x,
    input  logic signed [vnns_pkg::COORD_W-1:0]   src_y,
    input  logic signed [vnns_pkg::COORD_W-1:0]   src_z,
    input  logic [vnns_pkg::VALUE_W-1:0]          voxel_value,
    input  logic                                  last_source,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vnns_pkg::COORD_W-1:0]   dst_x,
    output logic signed [vnns_pkg::COORD_W-1:0]   dst_y,
    output logic signed [vnns_pkg::COORD_W-1:0]   dst_z,
    output logic [vnns_pkg::VALUE_W-1:0]          out_value,
    output logic [vnns_pkg::STATUS_W-1:0]         status,
    output logic                                  last_of_run,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_min_x,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_min_y,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_min_z,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_max_x,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_max_y,
    output logic signed [vnns_pkg::COORD_W-1:0]   bound_max_z
);

    localparam int CW = vnns_pkg::COORD_W;
    localparam int XW = vnns_pkg::EXT_W;
    localparam int DW = vnns_pkg::DIM_W;
    localparam int NW = vnns_pkg::NUM_W;
    localparam int SW = vnns_pkg::STEP_W;
    localparam int VW = vnns_pkg::VALUE_W;
    localparam int TW = vnns_pkg::STATUS_W;

    localparam logic signed [XW-1:0] C_MAX =
        XW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] C_MIN = -C_MAX - XW'(1);
    localparam logic [DW:0] DIM_LIMIT = (DW + 1)'(MAX_DIM);
    localparam logic [NW-1:0] SPAN_LIMIT = NW'(MAX_SPAN);
    localparam logic [2:0] LAST_DIV = 3'd5;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DLOAD  = 3'd2;
    localparam logic [2:0] S_DSTEP  = 3'd3;
    localparam logic [2:0] S_SPAN   = 3'd4;
    localparam logic [2:0] S_OVF    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_REPORT = 3'd7;

    // configuration
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] origin_next [3];
    logic [DW-1:0]        size_reg [3];
    logic [DW-1:0]        size_next [3];
    logic [3*DW-1:0]      targets_reg, targets_next;

    // sequencer and item
    logic [2:0]           state_reg, state_next;
    logic signed [CW-1:0] src_reg [3];
    logic signed [CW-1:0] src_next [3];
    logic [VW-1:0]        value_reg, value_next;
    logic                 last_reg, last_next;
    logic [DW-1:0]        local_reg [3];
    logic [DW-1:0]        local_next [3];
    logic [NW-1:0]        lo_reg [3];
    logic [NW-1:0]        lo_next [3];
    logic [NW-1:0]        hi_reg [3];
    logic [NW-1:0]        hi_next [3];
    logic [NW-1:0]        cnt_reg [3];
    logic [NW-1:0]        cnt_next [3];
    logic [TW-1:0]        err_reg, err_next;
    logic                 empty_reg, empty_next;

    // shared divider
    logic [2:0]           div_idx_reg, div_idx_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [NW-1:0]        num_reg, num_next;
    logic [DW-1:0]        rem_reg, rem_next;

    // run state
    logic signed [CW-1:0] low_reg [3];
    logic signed [CW-1:0] low_next [3];
    logic signed [CW-1:0] high_reg [3];
    logic signed [CW-1:0] high_next [3];
    logic                 any_reg, any_next;
    logic                 failed_reg, failed_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] o_dst_reg [3];
    logic signed [CW-1:0] o_dst_next [3];
    logic signed [CW-1:0] o_min_reg [3];
    logic signed [CW-1:0] o_min_next [3];
    logic signed [CW-1:0] o_max_reg [3];
    logic signed [CW-1:0] o_max_next [3];
    logic [VW-1:0]        o_value_reg, o_value_next;
    logic [TW-1:0]        o_status_reg, o_status_next;
    logic                 o_last_reg, o_last_next;

    logic [DW-1:0] tgt [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            tgt[a] = targets_reg[a*DW +: DW];
        end
    end

    always_comb
    begin
        logic                 out_free;
        logic                 dims_bad;
        logic                 outside;
        logic                 span_bad;
        logic                 any_empty;
        logic                 ovf;
        logic [TW-1:0]        err_final;
        logic signed [XW-1:0] diff;
        logic [1:0]           axis;
        logic [DW-1:0]        mul_a;
        logic [DW:0]          trial;
        logic                 ge;
        logic [NW-1:0]        quot;
        logic [NW-1:0]        ceil_q;
        logic [NW-1:0]        span;
        logic signed [XW-1:0] org_ext;
        logic signed [CW-1:0] d [3];
        logic                 end_x;
        logic                 end_y;
        logic                 end_z;
        logic                 fin_box;
        logic                 end_run;

        out_free   = !out_valid_reg || !out_stall;
        dims_bad   = 1'b0;
        outside    = 1'b0;
        span_bad   = 1'b0;
        any_empty  = 1'b0;
        ovf        = 1'b0;
        err_final  = err_reg;
        diff       = '0;
        axis       = div_idx_reg[2:1];
        mul_a      = '0;
        trial      = {rem_reg, num_reg[NW-1]};
        ge         = trial >= {1'b0, size_reg[axis]};
        quot       = {num_reg[NW-2:0], ge};
        ceil_q     = '0;
        span       = '0;
        org_ext    = '0;
        end_run    = 1'b0;

        for (int a = 0; a < 3; a++)
        begin
            d[a] = origin_reg[a] + CW'(cnt_reg[a]);
        end
        end_x   = (cnt_reg[0] + NW'(1)) == hi_reg[0];
        end_y   = (cnt_reg[1] + NW'(1)) == hi_reg[1];
        end_z   = (cnt_reg[2] + NW'(1)) == hi_reg[2];
        fin_box = end_x && end_y && end_z;

        // configuration port
        origin_next  = origin_reg;
        size_next    = size_reg;
        targets_next = targets_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                vnns_pkg::REG_ORIGIN_X: origin_next[0] = cfg_data;
                vnns_pkg::REG_ORIGIN_Y: origin_next[1] = cfg_data;
                vnns_pkg::REG_ORIGIN_Z: origin_next[2] = cfg_data;
                vnns_pkg::REG_SIZE_X:   size_next[0]   = cfg_data[DW-1:0];
                vnns_pkg::REG_SIZE_Y:   size_next[1]   = cfg_data[DW-1:0];
                vnns_pkg::REG_SIZE_Z:   size_next[2]   = cfg_data[DW-1:0];
                vnns_pkg::REG_TARGETS:  targets_next   = cfg_data[3*DW-1:0];
                default:                ;
            endcase
        end

        state_next   = state_reg;
        src_next     = src_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        local_next   = local_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        empty_next   = empty_reg;
        div_idx_next = div_idx_reg;
        step_next    = step_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        any_next     = any_reg;
        failed_next  = failed_reg;

        out_valid_next = out_valid_reg && out_stall;
        o_dst_next     = o_dst_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;
        o_value_next   = o_value_reg;
        o_status_next  = o_status_reg;
        o_last_next    = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    src_next[0] = src_x;
                    src_next[1] = src_y;
                    src_next[2] = src_z;
                    value_next  = voxel_value;
                    last_next   = last_source;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (size_reg[a] == '0 || {1'b0, size_reg[a]} > DIM_LIMIT ||
                        tgt[a] == '0 || {1'b0, tgt[a]} > DIM_LIMIT)
                    begin
                        dims_bad = 1'b1;
                    end
                    diff = XW'(src_reg[a]) - XW'(origin_reg[a]);
                    if (diff < 0 || diff >= $signed(XW'(size_reg[a])))
                    begin
                        outside = 1'b1;
                    end
                    local_next[a] = diff[DW-1:0];
                end
                if (dims_bad)
                begin
                    err_next   = vnns_pkg::ST_BAD_DIMS;
                    state_next = S_REPORT;
                end
                else if (outside)
                begin
                    err_next   = vnns_pkg::ST_OUTSIDE;
                    state_next = S_REPORT;
                end
                else
                begin
                    err_next     = vnns_pkg::ST_OK;
                    div_idx_next = '0;
                    state_next   = S_DLOAD;
                end
            end

            S_DLOAD:
            begin
                mul_a      = local_reg[axis] + DW'(div_idx_reg[0]);
                num_next   = NW'(mul_a) * NW'(tgt[axis]);
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DSTEP;
            end

            S_DSTEP:
            begin
                rem_next  = ge ? DW'(trial - {1'b0, size_reg[axis]}) : trial[DW-1:0];
                num_next  = quot;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(NW - 1))
                begin
                    ceil_q = quot + NW'(rem_next != '0);
                    if (div_idx_reg[0])
                    begin
                        hi_next[axis] = ceil_q;
                    end
                    else
                    begin
                        lo_next[axis] = ceil_q;
                    end
                    if (div_idx_reg == LAST_DIV)
                    begin
                        state_next = S_SPAN;
                    end
                    else
                    begin
                        div_idx_next = div_idx_reg + 3'd1;
                        state_next   = S_DLOAD;
                    end
                end
            end

            S_SPAN:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    span = hi_reg[a] - lo_reg[a];
                    if (span > SPAN_LIMIT)
                    begin
                        span_bad = 1'b1;
                    end
                    if (hi_reg[a] == lo_reg[a])
                    begin
                        any_empty = 1'b1;
                    end
                end
                err_next   = span_bad ? vnns_pkg::ST_BAD_DIMS : vnns_pkg::ST_OK;
                empty_next = any_empty;
                state_next = S_OVF;
            end

            S_OVF:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    org_ext = XW'(origin_reg[a]);
                    if (org_ext + $signed(XW'(lo_reg[a])) < C_MIN ||
                        org_ext + $signed(XW'(hi_reg[a])) - XW'(1) > C_MAX)
                    begin
                        ovf = 1'b1;
                    end
                end
                if (err_reg == vnns_pkg::ST_OK && !empty_reg && ovf)
                begin
                    err_final = vnns_pkg::ST_OVERFLOW;
                end
                err_next = err_final;
                for (int a = 0; a < 3; a++)
                begin
                    cnt_next[a] = lo_reg[a];
                end
                if (failed_reg || err_final != vnns_pkg::ST_OK)
                begin
                    state_next = S_REPORT;
                end
                else if (empty_reg)
                begin
                    state_next = last_reg ? S_REPORT : S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        if (!any_reg || d[a] < low_reg[a])
                        begin
                            low_next[a] = d[a];
                        end
                        if (!any_reg || d[a] > high_reg[a])
                        begin
                            high_next[a] = d[a];
                        end
                        o_dst_next[a] = d[a];
                        o_min_next[a] = (last_reg && fin_box) ? low_next[a] : '0;
                        o_max_next[a] = (last_reg && fin_box) ? high_next[a] : '0;
                    end
                    any_next       = 1'b1;
                    out_valid_next = 1'b1;
                    o_value_next   = value_reg;
                    o_status_next  = vnns_pkg::ST_OK;
                    o_last_next    = last_reg && fin_box;

                    if (!end_x)
                    begin
                        cnt_next[0] = cnt_reg[0] + NW'(1);
                    end
                    else
                    begin
                        cnt_next[0] = lo_reg[0];
                        if (!end_y)
                        begin
                            cnt_next[1] = cnt_reg[1] + NW'(1);
                        end
                        else
                        begin
                            cnt_next[1] = lo_reg[1];
                            cnt_next[2] = cnt_reg[2] + NW'(1);
                        end
                    end

                    if (fin_box)
                    begin
                        end_run    = last_reg;
                        state_next = S_IDLE;
                    end
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_value_next   = '0;
                    o_last_next    = last_reg;
                    for (int a = 0; a < 3; a++)
                    begin
                        o_dst_next[a] = '0;
                        o_min_next[a] = '0;
                        o_max_next[a] = '0;
                    end
                    if (failed_reg || err_reg != vnns_pkg::ST_OK)
                    begin
                        o_status_next = (err_reg != vnns_pkg::ST_OK) ? err_reg
                                                                    : vnns_pkg::ST_EMPTY;
                        failed_next   = 1'b1;
                    end
                    else
                    begin
                        o_status_next = any_reg ? vnns_pkg::ST_BOUNDS : vnns_pkg::ST_EMPTY;
                        if (any_reg)
                        begin
                            o_min_next = low_reg;
                            o_max_next = high_reg;
                        end
                    end
                    end_run    = last_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of run clears the bounds and flags
        if (end_run)
        begin
            for (int a = 0; a < 3; a++)
            begin
                low_next[a]  = '0;
                high_next[a] = '0;
            end
            any_next    = 1'b0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a] <= '0;
                size_reg[a]   <= vnns_pkg::SIZE_RESET;
                low_reg[a]    <= '0;
                high_reg[a]   <= '0;
            end
            targets_reg   <= vnns_pkg::TARGETS_RESET;
            state_reg     <= S_IDLE;
            any_reg       <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            origin_reg    <= origin_next;
            size_reg      <= size_next;
            targets_reg   <= targets_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            state_reg     <= state_next;
            any_reg       <= any_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
        local_reg    <= local_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        cnt_reg      <= cnt_next;
        err_reg      <= err_next;
        empty_reg    <= empty_next;
        div_idx_reg  <= div_idx_next;
        step_reg     <= step_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        o_dst_reg    <= o_dst_next;
        o_min_reg    <= o_min_next;
        o_max_reg    <= o_max_next;
        o_value_reg  <= o_value_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign dst_x       = o_dst_reg[0];
    assign dst_y       = o_dst_reg[1];
    assign dst_z       = o_dst_reg[2];
    assign out_value   = o_value_reg;
    assign status      = o_status_reg;
    assign last_of_run = o_last_reg;
    assign bound_min_x = o_min_reg[0];
    assign bound_min_y = o_min_reg[1];
    assign bound_min_z = o_min_reg[2];
    assign bound_max_x = o_max_reg[0];
    assign bound_max_y = o_max_reg[1];
    assign bound_max_z = o_max_reg[2];

endmodule

### bench/tb_voxel_nearest_neighbor_scaler_unit.sv
// self-checking bench for the nearest-neighbour voxel resampler
// directed corner cases, then random selections under idle and stall phases
// depends on vnns_pkg and voxel_nearest_neighbor_scaler_unit
module tb_voxel_nearest_neighbor_scaler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 42;
    localparam longint COORD_MAX =
        (longint'(1) <<< (vnns_pkg::COORD_BITS_DEF - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic [vnns_pkg::CFG_IDX_W-1:0] REG_UNUSED = {vnns_pkg::CFG_IDX_W{1'b1}};
    localparam logic [vnns_pkg::COORD_W-1:0] TOP_COORD =
        {1'b0, {(vnns_pkg::COORD_W-1){1'b1}}};
    localparam logic [vnns_pkg::COORD_W-1:0] BOTTOM_COORD =
        {1'b1, {(vnns_pkg::COORD_W-1){1'b0}}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    typedef struct packed {
        logic [2:0][vnns_pkg::COORD_W-1:0] pos;
        logic [vnns_pkg::VALUE_W-1:0]      value;
        logic                              last;
        logic                              hold;
    } voxel_t;

    typedef struct packed {
        logic [2:0][vnns_pkg::COORD_W-1:0] dst;
        logic [vnns_pkg::VALUE_W-1:0]      value;
        logic [vnns_pkg::STATUS_W-1:0]     st;
        logic                              last;
        logic [2:0][vnns_pkg::COORD_W-1:0] bmin;
        logic [2:0][vnns_pkg::COORD_W-1:0] bmax;
    } dest_t;

    typedef struct packed {
        logic [2:0][vnns_pkg::COORD_W-1:0] origin;
        logic [2:0][vnns_pkg::DIM_W-1:0]   ext;
        logic [2:0][vnns_pkg::DIM_W-1:0]   tgt;
    } selection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [vnns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vnns_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [vnns_pkg::COORD_W-1:0] src_x = '0;
    logic signed [vnns_pkg::COORD_W-1:0] src_y = '0;
    logic signed [vnns_pkg::COORD_W-1:0] src_z = '0;
    logic [vnns_pkg::VALUE_W-1:0] voxel_value = '0;
    logic last_source = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [vnns_pkg::COORD_W-1:0] dst_x, dst_y, dst_z;
    logic [vnns_pkg::VALUE_W-1:0] out_value;
    logic [vnns_pkg::STATUS_W-1:0] status;
    logic last_of_run;
    logic signed [vnns_pkg::COORD_W-1:0] bound_min_x, bound_min_y, bound_min_z;
    logic signed [vnns_pkg::COORD_W-1:0] bound_max_x, bound_max_y, bound_max_z;

    voxel_t voxel_q[$];
    dest_t  dest_q[$];

    selection_t cur_sel;
    longint lo_corner[3];
    longint hi_corner[3];
    bit any_dest;
    bit run_bad;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int sources_taken = 0;
    int dests_checked = 0;
    int selections_used = 0;

    voxel_nearest_neighbor_scaler_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_x       (src_x),
        .src_y       (src_y),
        .src_z       (src_z),
        .voxel_value (voxel_value),
        .last_source (last_source),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dst_x       (dst_x),
        .dst_y       (dst_y),
        .dst_z       (dst_z),
        .out_value   (out_value),
        .status      (status),
        .last_of_run (last_of_run),
        .bound_min_x (bound_min_x),
        .bound_min_y (bound_min_y),
        .bound_min_z (bound_min_z),
        .bound_max_x (bound_max_x),
        .bound_max_y (bound_max_y),
        .bound_max_z (bound_max_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void close_run();
        int a;
        for (a = 0; a < 3; a++)
        begin
            lo_corner[a] = 0;
            hi_corner[a] = 0;
        end
        any_dest = 1'b0;
        run_bad = 1'b0;
    endfunction

    function automatic void expect_beat(input dest_t r);
        dest_q = {dest_q, r};
    endfunction

    function automatic dest_t with_bounds(input dest_t r);
        dest_t b;
        int a;
        b = r;
        for (a = 0; a < 3; a++)
        begin
            b.bmin[a] = lo_corner[a][vnns_pkg::COORD_W-1:0];
            b.bmax[a] = hi_corner[a][vnns_pkg::COORD_W-1:0];
        end
        return b;
    endfunction

    // expected destination or status beats for one accepted source voxel
    function automatic void resample_voxel(input voxel_t v);
        longint src[3], org[3], ext[3], tgt[3], lo[3], hi[3], d[3];
        longint off, x, y, z;
        logic [vnns_pkg::STATUS_W-1:0] err;
        bit empty;
        bit fin;
        int a;
        dest_t r;
        err = vnns_pkg::ST_OK;
        empty = 1'b0;
        for (a = 0; a < 3; a++)
        begin
            src[a] = longint'($signed(v.pos[a]));
            org[a] = longint'($signed(cur_sel.origin[a]));
            ext[a] = longint'(cur_sel.ext[a]);
            tgt[a] = longint'(cur_sel.tgt[a]);
            if (ext[a] == 0 || ext[a] > vnns_pkg::MAX_DIM_DEF ||
                tgt[a] == 0 || tgt[a] > vnns_pkg::MAX_DIM_DEF)
                err = vnns_pkg::ST_BAD_DIMS;
        end
        if (err == vnns_pkg::ST_OK)
            for (a = 0; a < 3; a++)
                if (src[a] < org[a] || src[a] > org[a] + ext[a] - 1)
                    err = vnns_pkg::ST_OUTSIDE;
        if (err == vnns_pkg::ST_OK)
        begin
            for (a = 0; a < 3; a++)
            begin
                off = src[a] - org[a];
                lo[a] = (off * tgt[a] + ext[a] - 1) / ext[a];
                hi[a] = ((off + 1) * tgt[a] + ext[a] - 1) / ext[a];
                if (hi[a] - lo[a] > vnns_pkg::MAX_SPAN_DEF)
                    err = vnns_pkg::ST_BAD_DIMS;
                if (hi[a] == lo[a])
                    empty = 1'b1;
            end
            if (err == vnns_pkg::ST_OK && !empty)
                for (a = 0; a < 3; a++)
                    if (org[a] + lo[a] < COORD_MIN || org[a] + hi[a] - 1 > COORD_MAX)
                        err = vnns_pkg::ST_OVERFLOW;
        end

        if (run_bad || err != vnns_pkg::ST_OK)
        begin
            r = '0;
            r.st = (err != vnns_pkg::ST_OK) ? err : vnns_pkg::ST_EMPTY;
            r.last = v.last;
            expect_beat(r);
            run_bad = 1'b1;
            if (v.last)
                close_run();
            return;
        end

        if (!empty)
        begin
            for (z = lo[2]; z < hi[2]; z++)
                for (y = lo[1]; y < hi[1]; y++)
                    for (x = lo[0]; x < hi[0]; x++)
                    begin
                        d[0] = org[0] + x;
                        d[1] = org[1] + y;
                        d[2] = org[2] + z;
                        for (a = 0; a < 3; a++)
                        begin
                            if (!any_dest || d[a] < lo_corner[a])
                                lo_corner[a] = d[a];
                            if (!any_dest || d[a] > hi_corner[a])
                                hi_corner[a] = d[a];
                        end
                        any_dest = 1'b1;
                        fin = v.last && z == hi[2] - 1 && y == hi[1] - 1 && x == hi[0] - 1;
                        r = '0;
                        for (a = 0; a < 3; a++)
                            r.dst[a] = d[a][vnns_pkg::COORD_W-1:0];
                        r.value = v.value;
                        r.st = vnns_pkg::ST_OK;
                        r.last = fin;
                        if (fin)
                            r = with_bounds(r);
                        expect_beat(r);
                    end
        end
        else if (v.last)
        begin
            r = '0;
            r.st = any_dest ? vnns_pkg::ST_BOUNDS : vnns_pkg::ST_EMPTY;
            r.last = 1'b1;
            if (any_dest)
                r = with_bounds(r);
            expect_beat(r);
        end
        if (v.last)
            close_run();
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : source_driver
        bit took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                resample_voxel(voxel_q.pop_front());
                sources_taken++;
            end
            if (took || !in_valid)
            begin
                if (voxel_q.size() != 0 && !(voxel_q[0].hold && dest_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    src_x <= voxel_q[0].pos[0];
                    src_y <= voxel_q[0].pos[1];
                    src_z <= voxel_q[0].pos[2];
                    voxel_value <= voxel_q[0].value;
                    last_source <= voxel_q[0].last;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        dest_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (dest_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    mismatch_count++;
                end
                else
                begin
                    want = dest_q.pop_front();
                    check_field("dst_x", $signed(want.dst[0]), dst_x);
                    check_field("dst_y", $signed(want.dst[1]), dst_y);
                    check_field("dst_z", $signed(want.dst[2]), dst_z);
                    check_field("out_value", want.value, out_value);
                    check_field("status", want.st, status);
                    check_field("last_of_run", want.last, last_of_run);
                    check_field("bound_min_x", $signed(want.bmin[0]), bound_min_x);
                    check_field("bound_min_y", $signed(want.bmin[1]), bound_min_y);
                    check_field("bound_min_z", $signed(want.bmin[2]), bound_min_z);
                    check_field("bound_max_x", $signed(want.bmax[0]), bound_max_x);
                    check_field("bound_max_y", $signed(want.bmax[1]), bound_max_y);
                    check_field("bound_max_z", $signed(want.bmax[2]), bound_max_z);
                    dests_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_voxel(input logic [vnns_pkg::COORD_W-1:0] x,
                              input logic [vnns_pkg::COORD_W-1:0] y,
                              input logic [vnns_pkg::COORD_W-1:0] z,
                              input logic [vnns_pkg::VALUE_W-1:0] value,
                              input bit last, input bit hold);
        voxel_t v;
        v.pos[0] = x;
        v.pos[1] = y;
        v.pos[2] = z;
        v.value = value;
        v.last = last;
        v.hold = hold;
        voxel_q = {voxel_q, v};
    endtask

    // all beats taken, all results in, then time for a result-free item to finish
    task automatic settle();
        while (voxel_q.size() != 0 || in_valid)
            @(posedge clk);
        while (dest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vnns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vnns_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            vnns_pkg::REG_ORIGIN_X: cur_sel.origin[0] = data;
            vnns_pkg::REG_ORIGIN_Y: cur_sel.origin[1] = data;
            vnns_pkg::REG_ORIGIN_Z: cur_sel.origin[2] = data;
            vnns_pkg::REG_SIZE_X:   cur_sel.ext[0] = data[vnns_pkg::DIM_W-1:0];
            vnns_pkg::REG_SIZE_Y:   cur_sel.ext[1] = data[vnns_pkg::DIM_W-1:0];
            vnns_pkg::REG_SIZE_Z:   cur_sel.ext[2] = data[vnns_pkg::DIM_W-1:0];
            vnns_pkg::REG_TARGETS:  cur_sel.tgt = data[vnns_pkg::TGT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_selection(input selection_t s);
        logic [vnns_pkg::CFG_W-1:0] rnd;
        settle();
        write_reg(vnns_pkg::REG_ORIGIN_X, s.origin[0]);
        write_reg(vnns_pkg::REG_ORIGIN_Y, s.origin[1]);
        write_reg(vnns_pkg::REG_ORIGIN_Z, s.origin[2]);
        rnd = $urandom();
        write_reg(vnns_pkg::REG_SIZE_X, {rnd[vnns_pkg::CFG_W-1:vnns_pkg::DIM_W], s.ext[0]});
        rnd = $urandom();
        write_reg(vnns_pkg::REG_SIZE_Y, {rnd[vnns_pkg::CFG_W-1:vnns_pkg::DIM_W], s.ext[1]});
        rnd = $urandom();
        write_reg(vnns_pkg::REG_SIZE_Z, {rnd[vnns_pkg::CFG_W-1:vnns_pkg::DIM_W], s.ext[2]});
        rnd = $urandom();
        write_reg(vnns_pkg::REG_TARGETS, {rnd[vnns_pkg::CFG_W-1:vnns_pkg::TGT_W], s.tgt});
        write_reg(REG_UNUSED, $urandom());
        selections_used++;
    endtask

    function automatic selection_t make_selection(input logic [vnns_pkg::COORD_W-1:0] ox,
                                                  input logic [vnns_pkg::COORD_W-1:0] oy,
                                                  input logic [vnns_pkg::COORD_W-1:0] oz,
                                                  input int ex, input int ey, input int ez,
                                                  input int tx, input int ty, input int tz);
        selection_t s;
        s.origin[0] = ox;
        s.origin[1] = oy;
        s.origin[2] = oz;
        s.ext[0] = vnns_pkg::DIM_W'(ex);
        s.ext[1] = vnns_pkg::DIM_W'(ey);
        s.ext[2] = vnns_pkg::DIM_W'(ez);
        s.tgt[0] = vnns_pkg::DIM_W'(tx);
        s.tgt[1] = vnns_pkg::DIM_W'(ty);
        s.tgt[2] = vnns_pkg::DIM_W'(tz);
        return s;
    endfunction

    function automatic selection_t pick_selection();
        selection_t s;
        int kind, a, hot, top;
        kind = $urandom_range(99);
        top = (1 << vnns_pkg::DIM_W) - 1;
        for (a = 0; a < 3; a++)
        begin
            if (kind < 15)
            begin
                s.ext[a] = $urandom_range(1)
                           ? vnns_pkg::DIM_W'(vnns_pkg::MAX_DIM_DEF)
                           : vnns_pkg::DIM_W'($urandom_range(100, vnns_pkg::MAX_DIM_DEF));
                s.tgt[a] = vnns_pkg::DIM_W'($urandom_range(1, vnns_pkg::MAX_DIM_DEF));
            end
            else
            begin
                s.ext[a] = vnns_pkg::DIM_W'($urandom_range(1, 6));
                s.tgt[a] = vnns_pkg::DIM_W'($urandom_range(1, 4 * s.ext[a]));
            end
            s.origin[a] = ($urandom_range(9) < 7) ? $urandom_range(0, 2000) - 1000
                                                  : $urandom();
        end
        hot = $urandom_range(2);
        if (kind >= 70 && kind < 85)
        begin
            s.origin[hot] = TOP_COORD - $urandom_range(0, 8);
            s.origin[(hot + 1) % 3] = BOTTOM_COORD + $urandom_range(0, 8);
        end
        else if (kind >= 85)
        begin
            case ($urandom_range(4))
                0: s.ext[hot] = '0;
                1: s.ext[hot] = vnns_pkg::DIM_W'($urandom_range(vnns_pkg::MAX_DIM_DEF + 1, top));
                2: s.tgt[hot] = '0;
                3: s.tgt[hot] = vnns_pkg::DIM_W'($urandom_range(vnns_pkg::MAX_DIM_DEF + 1, top));
                default: s.tgt[hot] = vnns_pkg::DIM_W'(4 * s.ext[hot] + 1);
            endcase
        end
        return s;
    endfunction

    // runs of sources mostly inside the selection, some just outside, some anywhere
    task automatic fill_phase(input int count);
        logic [2:0][vnns_pkg::COORD_W-1:0] p;
        int k, i, a, r, run_len, hot;
        k = 0;
        while (k < count)
        begin
            run_len = $urandom_range(1, 6);
            for (i = 0; i < run_len; i++)
            begin
                r = $urandom_range(99);
                for (a = 0; a < 3; a++)
                    p[a] = cur_sel.origin[a]
                           + $urandom_range(0, cur_sel.ext[a] > 0 ? cur_sel.ext[a] - 1 : 0);
                hot = $urandom_range(2);
                if (r >= 88 && r < 94)
                    p[hot] = $urandom_range(1) ? cur_sel.origin[hot] - 1
                                               : cur_sel.origin[hot] + cur_sel.ext[hot];
                else if (r >= 94)
                    for (a = 0; a < 3; a++)
                        p[a] = $urandom();
                send_voxel(p[0], p[1], p[2], vnns_pkg::VALUE_W'($urandom_range(0, 255)),
                           i == run_len - 1, i == 0 && $urandom_range(29) == 0);
                k++;
            end
        end
    endtask

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 45;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 45;
            end
            default:
            begin
                send_idle_pct = 31;
                recv_stall_pct = 31;
            end
        endcase
    endtask

    initial
    begin : stimulus
        int phase;
        cur_sel = make_selection('0, '0, '0, vnns_pkg::SIZE_RESET, vnns_pkg::SIZE_RESET,
                                 vnns_pkg::SIZE_RESET,
                                 vnns_pkg::TARGETS_RESET[vnns_pkg::DIM_W-1:0],
                                 vnns_pkg::TARGETS_RESET[2*vnns_pkg::DIM_W-1:vnns_pkg::DIM_W],
                                 vnns_pkg::TARGETS_RESET[vnns_pkg::TGT_W-1:2*vnns_pkg::DIM_W]);
        close_run();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        // reset selection: single destinations, failed run, own error on last
        send_voxel('0, '0, '0, 8'hFF, 1'b0, 1'b0);
        send_voxel('0, '0, '0, 8'h00, 1'b1, 1'b1);
        send_voxel(TOP_COORD, BOTTOM_COORD, '0, 8'h3C, 1'b0, 1'b0);
        send_voxel('0, '0, '0, 8'h81, 1'b0, 1'b0);
        send_voxel(1, '0, '0, 8'h7E, 1'b1, 1'b0);

        // full 4x4x4 boxes at the bottom of the coordinate range
        load_selection(make_selection(BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD,
                                      4, 4, 4, 16, 16, 16));
        send_voxel(BOTTOM_COORD, BOTTOM_COORD + 1, BOTTOM_COORD + 3, 8'hA5, 1'b0, 1'b0);
        send_voxel(BOTTOM_COORD + 3, BOTTOM_COORD + 3, BOTTOM_COORD + 3, 8'h5A, 1'b1, 1'b0);

        // downscale: empty boxes, empty last with and without earlier destinations
        load_selection(make_selection(TOP_COORD - 3, 7, -7, 4, 4, 4, 2, 2, 2));
        send_voxel(TOP_COORD - 2, 8, -6, 8'h11, 1'b0, 1'b0);
        send_voxel(TOP_COORD - 2, 7, -7, 8'h22, 1'b1, 1'b0);
        send_voxel(TOP_COORD - 1, 9, -5, 8'h33, 1'b0, 1'b0);
        send_voxel(TOP_COORD, 10, -4, 8'h44, 1'b1, 1'b0);

        // destination past the top of the coordinate range
        load_selection(make_selection(TOP_COORD - 3, '0, '0, 4, 1, 1, 8, 1, 1));
        send_voxel(TOP_COORD - 3, '0, '0, 8'h55, 1'b0, 1'b0);
        send_voxel(TOP_COORD, '0, '0, 8'h66, 1'b0, 1'b0);
        send_voxel(TOP_COORD - 3, '0, '0, 8'h77, 1'b1, 1'b0);

        // bad dimensions: zero extent and target, extent and target above the limit, wide span
        load_selection(make_selection('0, '0, '0, 0, 256, 1, 1, 256, 1));
        send_voxel('0, '0, '0, 8'h88, 1'b0, 1'b0);
        send_voxel(5, 5, 5, 8'h99, 1'b1, 1'b0);
        load_selection(make_selection('0, '0, '0, 511, 1, 1, 1, 0, 1));
        send_voxel('0, '0, '0, 8'hAA, 1'b1, 1'b0);
        load_selection(make_selection('0, '0, '0, 1, 1, 1, 1, 1, 511));
        send_voxel('0, '0, '0, 8'hBB, 1'b1, 1'b0);
        load_selection(make_selection('0, '0, '0, 1, 1, 1, 5, 1, 1));
        send_voxel('0, '0, '0, 8'hCC, 1'b1, 1'b0);

        // largest legal extents
        load_selection(make_selection('0, '0, '0, 256, 256, 256, 256, 256, 256));
        send_voxel(255, 255, 255, 8'hFF, 1'b0, 1'b0);
        send_voxel('0, '0, '0, 8'h00, 1'b1, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_selection(pick_selection());
            set_idling(idling_t'(phase % 4));
            fill_phase(PHASE_ITEMS);
        end

        settle();
        $display("%0d source beats accepted, %0d result beats checked", sources_taken,
                 dests_checked);
        $display("%0d selections loaded, idle and stall phases on both channels",
                 selections_used);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #20ms;
        $display("timeout with %0d results outstanding", dest_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
